// ===== rtl/point_near_polygon_edge_test_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the point-near-polygon-edge test core
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef POINT_NEAR_POLYGON_EDGE_TEST_CORE_ASSERT_SVH
`define POINT_NEAR_POLYGON_EDGE_TEST_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PNPE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PNPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pnpe_pkg.sv =====
// ----------------------------------------------------------------------------
// pnpe_pkg
// Widths, command/status types and state encoding shared by the
// point-near-polygon-edge test core.
// ----------------------------------------------------------------------------
package pnpe_pkg;

  localparam int COORD_BITS  = 16;
  localparam int LIMIT_W     = 8;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(3);

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = COORD_BITS;

  // Datapath widths, derived from the coordinate and limit widths.
  localparam int DIFF_W  = COORD_BITS + 1;          // coordinate difference
  localparam int SPLIT_W = DIFF_W;                  // half-word split for wide products
  localparam int DOT_W   = 2 * DIFF_W + 1;          // signed dot product / cross term
  localparam int LEN_W   = 2 * DIFF_W;              // squared length
  localparam int ZM_W    = 2 * DIFF_W + 1;          // magnitude of cross term
  localparam int ZH_W    = ZM_W - SPLIT_W;          // upper half of cross magnitude
  localparam int LENH_W  = LEN_W - SPLIT_W;         // upper half of squared length
  localparam int LIM2_W  = 2 * LIMIT_W;             // squared limit
  localparam int MUL_W   = ((ZH_W > LIM2_W) ? ZH_W : LIM2_W) + 1;
  localparam int PM_W    = 2 * MUL_W;               // multiplier product
  localparam int Z2_W    = 2 * ZM_W;                // squared cross term
  localparam int ACC_W   = Z2_W + 1;                // signed accumulator
  localparam int L2LEN_W = LIM2_W + LEN_W;          // limit^2 * length^2

  localparam int NUM_STEPS = 20;                    // 19 products plus one drain slot
  localparam int STEP_W    = $clog2(NUM_STEPS);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POINT_X    = 2'd0,
    CFG_POINT_Y    = 2'd1,
    CFG_NEAR_LIMIT = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_RUN,
    ST_DECIDE,
    ST_EMIT
  } state_e;

  // Edge under test: previous->current, or current->first on close.
  typedef enum logic {
    SEG_OPEN,
    SEG_CLOSE
  } seg_e;

  typedef enum logic [4:0] {
    OP_L_L,
    OP_ABX_ACY,
    OP_ABY_ACX,
    OP_ABX_ABX,
    OP_ABY_ABY,
    OP_ZH_ZH,
    OP_ZH_ZL,
    OP_ZL_ZL,
    OP_L2_LENH,
    OP_L2_LENL,
    OP_ABX_BCX,
    OP_ABY_BCY,
    OP_ABX_ACX,
    OP_ABY_ACY,
    OP_BCX_BCX,
    OP_BCY_BCY,
    OP_ACX_ACX,
    OP_ACY_ACY
  } mul_op_e;

  typedef enum logic [1:0] {
    SH_NONE,
    SH_ONE,
    SH_TWO
  } shift_e;

  typedef enum logic [3:0] {
    DST_NONE,
    DST_LIM2,
    DST_Z,
    DST_LEN2,
    DST_Z2,
    DST_L2LEN,
    DST_DOT1,
    DST_DOT2,
    DST_BC2,
    DST_AC2
  } acc_dst_e;

  typedef struct packed {
    logic     capture;    // latch the incoming vertex
    logic     first;      // vertex opens a polygon
    logic     load_diff;  // form edge differences
    seg_e     seg_sel;
    logic     advance;    // previous <= current
    logic     mul_valid;
    mul_op_e  op;
    logic     clr;
    logic     sub;
    shift_e   shift;
    acc_dst_e dst;
  } dp_cmd_t;

  typedef struct packed {
    logic near;           // current edge passes the distance test
  } dp_status_t;

endpackage

// ===== rtl/pnpe_datapath.sv =====
// ----------------------------------------------------------------------------
// pnpe_datapath
// Vertex and config registers, edge differences, one shared multiplier with
// a shifting accumulator, and the per-edge distance decision.
// ----------------------------------------------------------------------------
module pnpe_datapath (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [pnpe_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [pnpe_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  input  logic signed [pnpe_pkg::COORD_BITS-1:0] vertex_x_i,
  input  logic signed [pnpe_pkg::COORD_BITS-1:0] vertex_y_i,
  input  pnpe_pkg::dp_cmd_t                      cmd_i,
  output pnpe_pkg::dp_status_t                   status_o
);
  import pnpe_pkg::*;

  typedef struct packed {
    logic     valid;
    logic     clr;
    logic     sub;
    shift_e   shift;
    acc_dst_e dst;
  } acc_cmd_t;

  logic signed [COORD_BITS-1:0] point_x_q, point_y_q;
  logic [LIMIT_W-1:0]           near_limit_q;

  logic signed [COORD_BITS-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q;
  logic signed [COORD_BITS-1:0] ax, ay, bx, by;

  logic signed [DIFF_W-1:0] abx_q, aby_q, bcx_q, bcy_q, acx_q, acy_q;

  logic signed [DOT_W-1:0] dot1_q, dot2_q;
  logic signed [ZM_W-1:0]  z_q;
  logic [LEN_W-1:0]        len2_q, bc2_q, ac2_q;
  logic [LIM2_W-1:0]       lim2_q;
  logic [Z2_W-1:0]         z2_q;
  logic [L2LEN_W-1:0]      l2len_q;

  logic [ZM_W-1:0]         zm;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [PM_W-1:0]  prod_q;
  acc_cmd_t                acc_cmd_q;
  logic signed [ACC_W-1:0] acc_q, acc_d, term, term_sh, base;
  logic                    dot1_pos;

  function automatic logic signed [DIFF_W-1:0] sx(input logic signed [COORD_BITS-1:0] v);
    return {v[COORD_BITS-1], v};
  endfunction

  function automatic logic signed [MUL_W-1:0] ext_d(input logic signed [DIFF_W-1:0] v);
    return {{(MUL_W-DIFF_W){v[DIFF_W-1]}}, v};
  endfunction

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_x_q    <= '0;
      point_y_q    <= '0;
      near_limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_POINT_X:    point_x_q    <= cfg_wdata_i;
        CFG_POINT_Y:    point_y_q    <= cfg_wdata_i;
        CFG_NEAR_LIMIT: near_limit_q <= cfg_wdata_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Vertex registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cur_x_q <= vertex_x_i;
      cur_y_q <= vertex_y_i;
      if (cmd_i.first) begin
        first_x_q <= vertex_x_i;
        first_y_q <= vertex_y_i;
        prev_x_q  <= vertex_x_i;
        prev_y_q  <= vertex_y_i;
      end
    end else if (cmd_i.advance) begin
      prev_x_q <= cur_x_q;
      prev_y_q <= cur_y_q;
    end
  end

  always_comb begin
    if (cmd_i.seg_sel == SEG_CLOSE) begin
      ax = cur_x_q;
      ay = cur_y_q;
      bx = first_x_q;
      by = first_y_q;
    end else begin
      ax = prev_x_q;
      ay = prev_y_q;
      bx = cur_x_q;
      by = cur_y_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_diff) begin
      abx_q <= sx(bx) - sx(ax);
      aby_q <= sx(by) - sx(ay);
      bcx_q <= sx(point_x_q) - sx(bx);
      bcy_q <= sx(point_y_q) - sx(by);
      acx_q <= sx(point_x_q) - sx(ax);
      acy_q <= sx(point_y_q) - sx(ay);
    end
  end

  assign zm = z_q[ZM_W-1] ? ZM_W'(-z_q) : ZM_W'(z_q);

  // Multiplier operand select.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_L_L: begin
        mul_a = signed'(MUL_W'(near_limit_q));
        mul_b = signed'(MUL_W'(near_limit_q));
      end
      OP_ABX_ACY: begin mul_a = ext_d(abx_q); mul_b = ext_d(acy_q); end
      OP_ABY_ACX: begin mul_a = ext_d(aby_q); mul_b = ext_d(acx_q); end
      OP_ABX_ABX: begin mul_a = ext_d(abx_q); mul_b = ext_d(abx_q); end
      OP_ABY_ABY: begin mul_a = ext_d(aby_q); mul_b = ext_d(aby_q); end
      OP_ZH_ZH: begin
        mul_a = signed'(MUL_W'(zm[ZM_W-1:SPLIT_W]));
        mul_b = signed'(MUL_W'(zm[ZM_W-1:SPLIT_W]));
      end
      OP_ZH_ZL: begin
        mul_a = signed'(MUL_W'(zm[ZM_W-1:SPLIT_W]));
        mul_b = signed'(MUL_W'(zm[SPLIT_W-1:0]));
      end
      OP_ZL_ZL: begin
        mul_a = signed'(MUL_W'(zm[SPLIT_W-1:0]));
        mul_b = signed'(MUL_W'(zm[SPLIT_W-1:0]));
      end
      OP_L2_LENH: begin
        mul_a = signed'(MUL_W'(lim2_q));
        mul_b = signed'(MUL_W'(len2_q[LEN_W-1:SPLIT_W]));
      end
      OP_L2_LENL: begin
        mul_a = signed'(MUL_W'(lim2_q));
        mul_b = signed'(MUL_W'(len2_q[SPLIT_W-1:0]));
      end
      OP_ABX_BCX: begin mul_a = ext_d(abx_q); mul_b = ext_d(bcx_q); end
      OP_ABY_BCY: begin mul_a = ext_d(aby_q); mul_b = ext_d(bcy_q); end
      OP_ABX_ACX: begin mul_a = ext_d(abx_q); mul_b = ext_d(acx_q); end
      OP_ABY_ACY: begin mul_a = ext_d(aby_q); mul_b = ext_d(acy_q); end
      OP_BCX_BCX: begin mul_a = ext_d(bcx_q); mul_b = ext_d(bcx_q); end
      OP_BCY_BCY: begin mul_a = ext_d(bcy_q); mul_b = ext_d(bcy_q); end
      OP_ACX_ACX: begin mul_a = ext_d(acx_q); mul_b = ext_d(acx_q); end
      OP_ACY_ACY: begin mul_a = ext_d(acy_q); mul_b = ext_d(acy_q); end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Product stage.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_valid) begin
      prod_q <= mul_a * mul_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_cmd_q <= '0;
    end else begin
      acc_cmd_q.valid <= cmd_i.mul_valid;
      acc_cmd_q.clr   <= cmd_i.clr;
      acc_cmd_q.sub   <= cmd_i.sub;
      acc_cmd_q.shift <= cmd_i.shift;
      acc_cmd_q.dst   <= cmd_i.dst;
    end
  end

  // Accumulate stage.
  always_comb begin
    term = ACC_W'(prod_q);
    case (acc_cmd_q.shift)
      SH_NONE: term_sh = term;
      SH_ONE:  term_sh = term <<< SPLIT_W;
      SH_TWO:  term_sh = term <<< (2 * SPLIT_W);
      default: term_sh = term;
    endcase
    base  = acc_cmd_q.clr ? '0 : acc_q;
    acc_d = acc_cmd_q.sub ? (base - term_sh) : (base + term_sh);
  end

  always_ff @(posedge clk_i) begin
    if (acc_cmd_q.valid) begin
      acc_q <= acc_d;
      case (acc_cmd_q.dst)
        DST_NONE:  ;
        DST_LIM2:  lim2_q  <= acc_d[LIM2_W-1:0];
        DST_Z:     z_q     <= acc_d[ZM_W-1:0];
        DST_LEN2:  len2_q  <= acc_d[LEN_W-1:0];
        DST_Z2:    z2_q    <= acc_d[Z2_W-1:0];
        DST_L2LEN: l2len_q <= acc_d[L2LEN_W-1:0];
        DST_DOT1:  dot1_q  <= acc_d[DOT_W-1:0];
        DST_DOT2:  dot2_q  <= acc_d[DOT_W-1:0];
        DST_BC2:   bc2_q   <= acc_d[LEN_W-1:0];
        DST_AC2:   ac2_q   <= acc_d[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Edge decision: beyond B, beyond A, degenerate edge, then perpendicular band.
  assign dot1_pos = !dot1_q[DOT_W-1] && (dot1_q != '0);

  always_comb begin
    if (dot1_pos) begin
      status_o.near = (bc2_q <= LEN_W'(lim2_q));
    end else if (dot2_q[DOT_W-1]) begin
      status_o.near = (ac2_q <= LEN_W'(lim2_q));
    end else if (len2_q == '0) begin
      status_o.near = (ac2_q <= LEN_W'(lim2_q));
    end else if (z_q[ZM_W-1]) begin
      status_o.near = (z2_q < Z2_W'(len2_q));
    end else begin
      status_o.near = (z2_q <= Z2_W'(l2len_q));
    end
  end

endmodule

// ===== rtl/pnpe_ctrl.sv =====
// ----------------------------------------------------------------------------
// pnpe_ctrl
// Sequencer: accepts vertices, steps the multiply/accumulate program for each
// edge, keeps the polygon flags and owns the result register.
// ----------------------------------------------------------------------------
module pnpe_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   last_vertex_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   near_boundary_o,
  output pnpe_pkg::dp_cmd_t      cmd_o,
  input  pnpe_pkg::dp_status_t   status_i
);
  import pnpe_pkg::*;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  seg_e              seg_q, seg_d;
  logic              last_q, last_d;
  logic              have_first_q, have_first_d;
  logic              near_found_q, near_found_d;
  logic              out_valid_q, out_valid_d;
  logic              near_q, near_d;
  logic              out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      step_q       <= '0;
      seg_q        <= SEG_OPEN;
      last_q       <= 1'b0;
      have_first_q <= 1'b0;
      near_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      step_q       <= step_d;
      seg_q        <= seg_d;
      last_q       <= last_d;
      have_first_q <= have_first_d;
      near_found_q <= near_found_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    near_q <= near_d;
  end

  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    seg_d        = seg_q;
    last_d       = last_q;
    have_first_d = have_first_q;
    near_found_d = near_found_q;
    out_load     = 1'b0;

    cmd_o           = '0;
    cmd_o.seg_sel   = seg_q;
    cmd_o.op        = OP_L_L;
    cmd_o.shift     = SH_NONE;
    cmd_o.dst       = DST_NONE;

    in_stall_o = (state_q != ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          cmd_o.first   = !have_first_q;
          have_first_d  = 1'b1;
          last_d        = last_vertex_i;
          if (have_first_q) begin
            seg_d   = SEG_OPEN;
            state_d = ST_DIFF;
          end else if (last_vertex_i) begin
            // single-vertex polygon: only the degenerate closing edge
            seg_d   = SEG_CLOSE;
            state_d = ST_DIFF;
          end
        end
      end

      ST_DIFF: begin
        cmd_o.load_diff = 1'b1;
        step_d          = '0;
        state_d         = ST_RUN;
      end

      ST_RUN: begin
        cmd_o.mul_valid = 1'b1;
        case (step_q)
          STEP_W'(0):  begin cmd_o.op = OP_L_L;     cmd_o.clr = 1'b1; cmd_o.dst = DST_LIM2; end
          STEP_W'(1):  begin cmd_o.op = OP_ABX_ACY; cmd_o.clr = 1'b1; end
          STEP_W'(2):  begin cmd_o.op = OP_ABY_ACX; cmd_o.sub = 1'b1; cmd_o.dst = DST_Z; end
          STEP_W'(3):  begin cmd_o.op = OP_ABX_ABX; cmd_o.clr = 1'b1; end
          STEP_W'(4):  begin cmd_o.op = OP_ABY_ABY; cmd_o.dst = DST_LEN2; end
          STEP_W'(5):  begin cmd_o.op = OP_ZH_ZH;   cmd_o.clr = 1'b1; cmd_o.shift = SH_TWO; end
          STEP_W'(6):  begin cmd_o.op = OP_ZH_ZL;   cmd_o.shift = SH_ONE; end
          STEP_W'(7):  begin cmd_o.op = OP_ZH_ZL;   cmd_o.shift = SH_ONE; end
          STEP_W'(8):  begin cmd_o.op = OP_ZL_ZL;   cmd_o.dst = DST_Z2; end
          STEP_W'(9):  begin cmd_o.op = OP_L2_LENH; cmd_o.clr = 1'b1; cmd_o.shift = SH_ONE; end
          STEP_W'(10): begin cmd_o.op = OP_L2_LENL; cmd_o.dst = DST_L2LEN; end
          STEP_W'(11): begin cmd_o.op = OP_ABX_BCX; cmd_o.clr = 1'b1; end
          STEP_W'(12): begin cmd_o.op = OP_ABY_BCY; cmd_o.dst = DST_DOT1; end
          STEP_W'(13): begin cmd_o.op = OP_ABX_ACX; cmd_o.clr = 1'b1; end
          STEP_W'(14): begin cmd_o.op = OP_ABY_ACY; cmd_o.dst = DST_DOT2; end
          STEP_W'(15): begin cmd_o.op = OP_BCX_BCX; cmd_o.clr = 1'b1; end
          STEP_W'(16): begin cmd_o.op = OP_BCY_BCY; cmd_o.dst = DST_BC2; end
          STEP_W'(17): begin cmd_o.op = OP_ACX_ACX; cmd_o.clr = 1'b1; end
          STEP_W'(18): begin cmd_o.op = OP_ACY_ACY; cmd_o.dst = DST_AC2; end
          default:     cmd_o.mul_valid = 1'b0;  // drain the accumulate stage
        endcase
        if (step_q == STEP_W'(NUM_STEPS - 1)) begin
          state_d = ST_DECIDE;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end

      ST_DECIDE: begin
        if (status_i.near) begin
          near_found_d = 1'b1;
        end
        if (seg_q == SEG_OPEN) begin
          cmd_o.advance = 1'b1;
          if (last_q) begin
            seg_d   = SEG_CLOSE;
            state_d = ST_DIFF;
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_EMIT;
        end
      end

      ST_EMIT: begin
        // hold until the result register is free
        if (!out_valid_q || !out_stall_i) begin
          out_load     = 1'b1;
          near_found_d = 1'b0;
          have_first_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = (out_valid_q && out_stall_i) || out_load;
  assign near_d      = out_load ? near_found_q : near_q;

  assign out_valid_o     = out_valid_q;
  assign near_boundary_o = near_q;

endmodule

// ===== rtl/point_near_polygon_edge_test_core.sv =====
// ----------------------------------------------------------------------------
// point_near_polygon_edge_test_core
// Streams polygon vertices and reports whether a configured point lies within
// a configured distance of any polygon edge.
// ----------------------------------------------------------------------------
// Vertices arrive one beat at a time on the input channel; a beat with
// last_vertex set closes the polygon, and exactly one beat then leaves on the
// output channel with near_boundary = 1 if the query point (point_x, point_y)
// lies within near_limit of any edge, including the closing edge back to the
// first vertex. Distances are evaluated exactly with integer arithmetic in
// squared form: beyond an endpoint the endpoint distance counts, otherwise
// the signed perpendicular distance rounded up must lie in 0..near_limit. All
// products go through one shared 19x19 multiplier followed by a shifting
// accumulator, 19 products per edge; an edge runs a difference load, the
// multiply and drain slots, and a decision. A polygon's first vertex starts
// no edge work, each later one runs its edge, and the last also runs the
// closing edge (a single vertex only the degenerate one) before the result
// write. The result sits in an output register, so the next polygon's
// vertices are taken while a result still waits to be read; only a new result
// waits for that register to free. Configuration writes on cfg_we_i /
// cfg_index_i / cfg_wdata_i take effect at once and are expected only while
// the block is idle; an index beyond near_limit is dropped.
// ----------------------------------------------------------------------------
module point_near_polygon_edge_test_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [pnpe_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [pnpe_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [pnpe_pkg::COORD_BITS-1:0] vertex_x_i,
  input  logic signed [pnpe_pkg::COORD_BITS-1:0] vertex_y_i,
  input  logic                                   last_vertex_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   near_boundary_o
);
  import pnpe_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer: vertex handshake, per-edge program, polygon flags, result beat.
  pnpe_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .last_vertex_i   (last_vertex_i),
    .in_stall_o      (in_stall_o),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .near_boundary_o (near_boundary_o),
    .cmd_o           (cmd),
    .status_i        (status)
  );

  // Arithmetic: config and vertex registers, multiplier, accumulator, compare.
  pnpe_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .vertex_x_i  (vertex_x_i),
    .vertex_y_i  (vertex_y_i),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

// ===== rtl/pnpe_checker.sv =====
// ----------------------------------------------------------------------------
// pnpe_checker
// Port-level checks for the point-near-polygon-edge test core.
// ----------------------------------------------------------------------------
`include "point_near_polygon_edge_test_core_assert.svh"

module pnpe_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic last_vertex_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic near_boundary_o
);

  logic in_take;
  logic out_hold;

  assign in_take  = in_valid_i && !in_stall_o;
  assign out_hold = out_valid_o && out_stall_i;

  // A stalled result beat stays and keeps its value.
  `PNPE_ASSERT_NEXT(a_out_hold, out_hold, out_valid_o && $stable(near_boundary_o), "beat changed")

  // A closing vertex always starts edge work, so the input stalls next.
  `PNPE_ASSERT_NEXT(a_last_busy, in_take && last_vertex_i, in_stall_o, "close not busy")

  // A new result is only written while the block is busy.
  `PNPE_ASSERT_SAME(a_rise_busy, $rose(out_valid_o), $past(in_stall_o), "result with no work")

  // No result appears right after a vertex is taken.
  `PNPE_ASSERT_NEXT(a_no_early_result, in_take, !$rose(out_valid_o), "result after a vertex")

endmodule

bind point_near_polygon_edge_test_core pnpe_checker u_pnpe_checker (.*);

// ===== test/point_near_polygon_edge_test_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_near_polygon_edge_test_checker
// Follows register writes and vertex beats, predicts the near flag of every
// closed polygon with exact wide integer arithmetic, and compares it in order
// with the result beats of the core.
// ----------------------------------------------------------------------------
module point_near_polygon_edge_test_checker (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [pnpe_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [pnpe_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  input  logic                                   in_valid_i,
  input  logic                                   in_stall_i,
  input  logic signed [pnpe_pkg::COORD_BITS-1:0] vertex_x_i,
  input  logic signed [pnpe_pkg::COORD_BITS-1:0] vertex_y_i,
  input  logic                                   last_vertex_i,
  input  logic                                   out_valid_i,
  input  logic                                   out_stall_i,
  input  logic                                   near_boundary_i,
  output int                                     errors_o,
  output int                                     pending_o
);
  import pnpe_pkg::*;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  // wide enough for the squared cross term and limit^2 * length^2
  typedef logic signed [127:0] wide_t;

  coord_t               query_x, query_y;
  logic [LIMIT_W-1:0]   query_lim;
  coord_t               first_x, first_y, prev_x, prev_y;
  logic                 have_first, near_acc;
  logic                 near_q[$];
  logic                 exp_near;
  int                   errors, shown;

  function automatic logic edge_is_near(input coord_t ax, input coord_t ay,
                                        input coord_t bx, input coord_t by);
    wide_t a_x, a_y, b_x, b_y, c_x, c_y;
    wide_t abx, aby, bcx, bcy, acx, acy, lim2, len2, ac2, dot, z;
    a_x = ax; a_y = ay; b_x = bx; b_y = by;
    c_x = query_x; c_y = query_y;
    lim2 = query_lim;
    lim2 = lim2 * lim2;
    abx = b_x - a_x; aby = b_y - a_y;
    bcx = c_x - b_x; bcy = c_y - b_y;
    acx = c_x - a_x; acy = c_y - a_y;
    ac2 = acx * acx + acy * acy;
    // point lies past the far endpoint
    dot = abx * bcx + aby * bcy;
    if (dot > 0) return (bcx * bcx + bcy * bcy) <= lim2;
    // point lies before the near endpoint
    dot = abx * acx + aby * acy;
    if (dot < 0) return ac2 <= lim2;
    len2 = abx * abx + aby * aby;
    if (len2 == 0) return ac2 <= lim2;
    // ceil(z / len) within 0..limit, all squared
    z = abx * acy - aby * acx;
    if (z < 0) return (z * z) < len2;
    return (z * z) <= lim2 * len2;
  endfunction

  task automatic note_error(input string what);
    errors++;
    if (shown < 10) begin
      $display("%0t: %s", $realtime, what);
      shown++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_x    = '0;
      query_y    = '0;
      query_lim  = LIMIT_RESET;
      first_x    = '0;
      first_y    = '0;
      prev_x     = '0;
      prev_y     = '0;
      have_first = 1'b0;
      near_acc   = 1'b0;
      near_q.delete();
      errors     = 0;
      shown      = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_POINT_X:    query_x = cfg_wdata_i;
          CFG_POINT_Y:    query_y = cfg_wdata_i;
          CFG_NEAR_LIMIT: query_lim = cfg_wdata_i[LIMIT_W-1:0];
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        if (!have_first) begin
          first_x    = vertex_x_i;
          first_y    = vertex_y_i;
          have_first = 1'b1;
        end else if (edge_is_near(prev_x, prev_y, vertex_x_i, vertex_y_i)) begin
          near_acc = 1'b1;
        end
        prev_x = vertex_x_i;
        prev_y = vertex_y_i;
        if (last_vertex_i) begin
          if (edge_is_near(vertex_x_i, vertex_y_i, first_x, first_y)) near_acc = 1'b1;
          near_q.push_back(near_acc);
          have_first = 1'b0;
          near_acc   = 1'b0;
        end
      end

      if (out_valid_i && !out_stall_i) begin
        if (near_q.size() == 0) begin
          note_error($sformatf("result beat with no polygon pending, near_boundary %0b",
                               near_boundary_i));
        end else begin
          exp_near = near_q.pop_front();
          if (near_boundary_i !== exp_near)
            note_error($sformatf("near_boundary mismatch: expected %0b, got %0b",
                                 exp_near, near_boundary_i));
        end
      end

      errors_o  <= errors;
      pending_o <= near_q.size();
    end
  end

endmodule

// ===== test/tb_point_near_polygon_edge_test_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_near_polygon_edge_test_core
// Streams polygons into the core under a series of query points and limits,
// with random idle bursts on both channels; a checker beside the core predicts
// every near flag and counts mismatches, and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_point_near_polygon_edge_test_core;
  import pnpe_pkg::*;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // Index past the register list; the core must drop writes to it.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  localparam int TOTAL_VERTICES = 850;
  localparam int CALM_VERTICES  = 80;   // tail of the run without idling
  localparam int PHASE_VERTICES = 60;
  localparam int SETTLE_CYCLES  = 60;   // longer than the work for one closing vertex
  localparam int HOLD_CYCLES    = 400;  // long receiver hold-off

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_wdata;
  logic                      in_valid;
  logic                      in_stall;
  coord_t                    vertex_x, vertex_y;
  logic                      last_vertex;
  logic                      out_valid;
  logic                      out_stall;
  logic                      near_boundary;
  logic                      hold_req;

  int                        mismatches;
  int                        pending;
  int                        vertices_sent = 0;
  int                        gap_pct = 0;
  int                        stall_pct = 0;

  // Query currently loaded, used only to aim vertices at the point.
  coord_t                    cur_px = '0;
  coord_t                    cur_py = '0;
  logic [LIMIT_W-1:0]        cur_lim = LIMIT_RESET;

  point_near_polygon_edge_test_core u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .vertex_x_i      (vertex_x),
    .vertex_y_i      (vertex_y),
    .last_vertex_i   (last_vertex),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .near_boundary_o (near_boundary)
  );

  point_near_polygon_edge_test_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .vertex_x_i      (vertex_x),
    .vertex_y_i      (vertex_y),
    .last_vertex_i   (last_vertex),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .near_boundary_i (near_boundary),
    .errors_o        (mismatches),
    .pending_o       (pending)
  );

  always #5 clk = ~clk;

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("tb_point_near_polygon_edge_test_core: errors");
    $finish;
  end

  // Receiver side: random stall bursts, plus one long hold-off on request so
  // that the output register stays full and the core backs up into its input.
  initial begin : result_stall
    bit hold_done;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(1, 100) <= stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic int spread(input int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  function automatic coord_t extreme_coord();
    case ($urandom_range(0, 5))
      0:       return -32768;
      1:       return 32767;
      2:       return -32767;
      3:       return 32766;
      4:       return 0;
      default: return -1;
    endcase
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 10;
      2:       return 30;
      default: return 60;
    endcase
  endfunction

  // Mostly small polygons, now and then a long one; single vertices included.
  function automatic int poly_size();
    case ($urandom_range(0, 9))
      0:       return 1;
      8:       return $urandom_range(6, 9);
      9:       return $urandom_range(10, 16);
      default: return $urandom_range(2, 5);
    endcase
  endfunction

  // Offer one vertex beat, after an optional idle burst; return once taken.
  task automatic send_vertex(input coord_t x, input coord_t y, input logic closes);
    if ($urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    vertex_x    <= x;
    vertex_y    <= y;
    last_vertex <= closes;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    vertices_sent++;
  endtask

  // Aim most vertices around the query point so that edges land on both sides
  // of the limit; keep some far, full-range and extreme ones as noise.
  task automatic pick_vertex(output coord_t x, output coord_t y);
    int span;
    span = int'(cur_lim) + 4;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        x = coord_t'(int'(cur_px) + spread(span));
        y = coord_t'(int'(cur_py) + spread(span));
      end
      4, 5: begin
        x = coord_t'(int'(cur_px) + spread(300));
        y = coord_t'(int'(cur_py) + spread(300));
      end
      6: begin
        x = coord_t'($urandom);
        y = coord_t'($urandom);
      end
      7: begin
        x = extreme_coord();
        y = extreme_coord();
      end
      default: begin
        // long edge running past the point, offset across it by up to limit + 4
        if ($urandom_range(0, 1)) begin
          x = coord_t'(int'(cur_px) + spread(3000));
          y = coord_t'(int'(cur_py) + spread(span));
        end else begin
          x = coord_t'(int'(cur_px) + spread(span));
          y = coord_t'(int'(cur_py) + spread(3000));
        end
      end
    endcase
  endtask

  task automatic send_polygon(input int n);
    coord_t x, y;
    for (int i = 0; i < n; i++) begin
      pick_vertex(x, y);
      send_vertex(x, y, i == n - 1);
    end
  endtask

  task automatic send_phase(input int count);
    int start;
    start = vertices_sent;
    while (vertices_sent - start < count) send_polygon(poly_size());
  endtask

  // Drop valid, wait for every predicted result, then let the core settle.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Load all registers back to back; the spare index must change nothing.
  task automatic load_query(input coord_t px, input coord_t py,
                            input logic [LIMIT_W-1:0] lim);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_POINT_X;
    cfg_wdata <= px;
    @(posedge clk);
    cfg_index <= CFG_POINT_Y;
    cfg_wdata <= py;
    @(posedge clk);
    cfg_index <= CFG_NEAR_LIMIT;
    cfg_wdata <= {(CFG_DATA_W - LIMIT_W)'($urandom), lim};
    @(posedge clk);
    cfg_index <= CFG_IDX_SPARE;
    cfg_wdata <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_px  = px;
    cur_py  = py;
    cur_lim = lim;
  endtask

  initial begin
    cfg_we      <= 1'b0;
    cfg_index   <= CFG_POINT_X;
    cfg_wdata   <= '0;
    in_valid    <= 1'b0;
    vertex_x    <= '0;
    vertex_y    <= '0;
    last_vertex <= 1'b0;
    hold_req    <= 1'b0;
    rst_n       <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed polygons against the reset query: point at origin, limit 3.
    gap_pct   = 20;
    stall_pct = 20;
    send_vertex(0, 0, 1'b1);                 // single vertex on the point
    send_vertex(3, 0, 1'b1);                 // single vertex exactly at the limit
    send_vertex(3, 1, 1'b1);                 // just outside the limit
    send_vertex(-32768, -32768, 1'b1);       // far corner
    send_vertex(-100, 3, 1'b0);              // interior distance equal to limit
    send_vertex(100, 3, 1'b1);
    send_vertex(-100, 4, 1'b0);              // interior distance one past limit
    send_vertex(100, 4, 1'b1);
    send_vertex(4, 0, 1'b0);                 // point behind the near endpoint
    send_vertex(50, 0, 1'b1);
    send_vertex(10, 10, 1'b0);               // repeated vertex, zero-length edge
    send_vertex(10, 10, 1'b1);
    send_vertex(-32768, -32768, 1'b0);       // full-range triangles
    send_vertex(32767, -32768, 1'b0);
    send_vertex(32767, 32767, 1'b1);
    send_vertex(-32768, 32767, 1'b0);
    send_vertex(32767, 32767, 1'b0);
    send_vertex(0, -32768, 1'b1);
    send_vertex(-1, -1, 1'b0);               // edge through the point
    send_vertex(1, 1, 1'b1);
    send_vertex(32767, -32768, 1'b0);        // both edges lie on one segment near the point
    send_vertex(-1, 0, 1'b1);
    wait_results_drained();

    // Extremes of the query registers.
    load_query(-32768, 32767, 8'd255);
    send_phase(40);
    wait_results_drained();
    load_query(32767, -32768, 8'd0);
    send_phase(40);
    wait_results_drained();

    // A stretch with no idling at all.
    gap_pct   = 0;
    stall_pct = 0;
    load_query(0, 0, 8'd255);
    send_phase(40);

    // Long receiver hold-off while the sender keeps offering short polygons.
    gap_pct   = 10;
    stall_pct = 10;
    hold_req <= 1'b1;
    repeat (6) send_polygon(2);
    wait_results_drained();

    // Random queries, limits and idling mixes.
    while (vertices_sent < TOTAL_VERTICES - CALM_VERTICES) begin
      case ($urandom_range(0, 2))
        0:       load_query(coord_t'($urandom), coord_t'($urandom), 8'($urandom));
        1:       load_query(coord_t'(spread(50)), coord_t'(spread(50)),
                            8'($urandom_range(1, 10)));
        default: load_query(extreme_coord(), extreme_coord(),
                            $urandom_range(0, 1) ? 8'd0 : 8'd255);
      endcase
      gap_pct   = pick_pct();
      stall_pct = pick_pct();
      send_phase(PHASE_VERTICES);
      wait_results_drained();
    end

    // Tail of the run: both sides always ready.
    gap_pct   = 0;
    stall_pct = 0;
    load_query(coord_t'(spread(20)), coord_t'(spread(20)), 8'($urandom_range(0, 20)));
    send_phase(TOTAL_VERTICES - vertices_sent);
    wait_results_drained();

    if (mismatches == 0)
      $display("tb_point_near_polygon_edge_test_core: clean");
    else
      $display("tb_point_near_polygon_edge_test_core: errors");
    $finish;
  end

endmodule
